// File: design/mrp_pkg.sv
// Package for the multichannel rotation panner: sizes, item and queue types,
// and the quarter-sine gain table built at elaboration.
// No dependencies.
package mrp_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int MIN_CHANNELS    = 2;
    localparam int CHANNEL_RESET   = 2;
    localparam int CFG_W           = 4;
    localparam int CNT_W           = $clog2(MAX_CHANNELS + 1);
    localparam int LANE_W          = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_W        = 16;
    localparam int FRAC_W          = 15;
    localparam int GAIN_W          = 16;
    localparam int ONE_Q15         = 32768;
    localparam int GAIN_TABLE_SIZE = 256;
    localparam int IDX_W           = $clog2(GAIN_TABLE_SIZE + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [MAX_CHANNELS-1:0] t_lanes;

    typedef struct packed {
        t_sample sample_in_0;
        t_sample sample_in_1;
        t_sample sample_in_2;
        t_sample sample_in_3;
        t_sample sample_in_4;
        t_sample sample_in_5;
        t_sample sample_in_6;
        t_sample sample_in_7;
        t_sample rotation;
    } t_in_item;

    typedef struct packed {
        t_sample sample_out_0;
        t_sample sample_out_1;
        t_sample sample_out_2;
        t_sample sample_out_3;
        t_sample sample_out_4;
        t_sample sample_out_5;
        t_sample sample_out_6;
        t_sample sample_out_7;
    } t_out_item;

    // One classified frame waiting for the gain and mixing pipeline.
    typedef struct packed {
        t_lanes              samples;
        logic [CNT_W-1:0]    count;
        logic [LANE_W-1:0]   offset;
        logic [FRAC_W-1:0]   frac;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef logic [GAIN_W-1:0] t_gain_table [0:GAIN_TABLE_SIZE];

    // Entry k is sin(k/GAIN_TABLE_SIZE * pi/2) in Q1.15 from a truncating
    // Taylor series in Q2.30 through the x^11 term.
    function automatic t_gain_table build_gain_table();
        t_gain_table       tbl;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic [63:0]       g;
        logic signed [63:0] sum;
        for (int k = 0; k <= GAIN_TABLE_SIZE; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / GAIN_TABLE_SIZE;
            x2   = (x * x) >> 30;
            sum  = $signed(x);
            term = ((x * x2) >> 30) / 6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            g = (64'(sum) + 64'd16384) >> 15;
            if (g > 64'(ONE_Q15)) begin
                g = 64'(ONE_Q15);
            end
            tbl[k] = g[GAIN_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_gain_table GAIN_ROM = build_gain_table();

endpackage

// File: design/multichannel_rotation_panner.sv
// Multichannel equal-power rotation panner, top level.
// A result is strobed for one cycle once its item has passed through the queue
// and the mixing pipeline. Throughput: one item per cycle; the mixing pipeline
// never stalls, so the two-entry queue never fills and busy stays low.
// Reset (synchronous, active low) empties the queue and the pipeline and sets
// the channel count to 2.
module multichannel_rotation_panner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mrp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       start,
    input  mrp_pkg::t_in_item          i_item,
    output logic                       busy,
    output logic                       o_valid,
    output mrp_pkg::t_out_item         o_item
);

    logic                    w_push;
    logic                    w_pop;
    mrp_pkg::t_task          w_front_task;
    mrp_pkg::t_task          w_queue_task;
    mrp_pkg::t_queue_status  w_status;

    // The mixer takes a frame whenever one is waiting.
    assign w_pop = !w_status.empty;

    mrp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .i_item         (i_item),
        .i_queue_status (w_status),
        .busy           (busy),
        .o_push         (w_push),
        .o_task         (w_front_task)
    );

    mrp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_task   (w_front_task),
        .i_pop    (w_pop),
        .o_status (w_status),
        .o_task   (w_queue_task)
    );

    mrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop),
        .i_task  (w_queue_task),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// File: design/mrp_front.sv
// Front end of the panner: channel count register, item acceptance and
// position classification into rotation offset and blend fraction.
// Depends on mrp_pkg.
module mrp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mrp_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         start,
    input  mrp_pkg::t_in_item            i_item,
    input  mrp_pkg::t_queue_status       i_queue_status,
    output logic                         busy,
    output logic                         o_push,
    output mrp_pkg::t_task               o_task
);

    localparam int S_W = mrp_pkg::SAMPLE_W + mrp_pkg::CNT_W + 1;

    logic [mrp_pkg::CFG_W-1:0] r_channel_count;
    logic [mrp_pkg::CNT_W-1:0] count;
    logic signed [S_W-1:0]     s_raw;
    logic signed [S_W-1:0]     span;
    logic signed [S_W-1:0]     s_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= mrp_pkg::CFG_W'(mrp_pkg::CHANNEL_RESET);
        end else if (i_cfg_we) begin
            r_channel_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_channel_count < mrp_pkg::CFG_W'(mrp_pkg::MIN_CHANNELS)) begin
            count = mrp_pkg::CNT_W'(mrp_pkg::MIN_CHANNELS);
        end else if (r_channel_count > mrp_pkg::CFG_W'(mrp_pkg::MAX_CHANNELS)) begin
            count = mrp_pkg::CNT_W'(mrp_pkg::MAX_CHANNELS);
        end else begin
            count = mrp_pkg::CNT_W'(r_channel_count);
        end

        s_raw = S_W'(i_item.rotation) * S_W'($signed({1'b0, count}));
        span  = S_W'($signed({1'b0, count, {mrp_pkg::FRAC_W{1'b0}}}));

        // A position whose magnitude reaches the count acts as zero.
        if (s_raw <= -span || s_raw >= span) begin
            s_wrap = '0;
        end else if (s_raw < 0) begin
            s_wrap = s_raw + span;
        end else begin
            s_wrap = s_raw;
        end
    end

    always_comb begin
        o_task.samples[0] = i_item.sample_in_0;
        o_task.samples[1] = i_item.sample_in_1;
        o_task.samples[2] = i_item.sample_in_2;
        o_task.samples[3] = i_item.sample_in_3;
        o_task.samples[4] = i_item.sample_in_4;
        o_task.samples[5] = i_item.sample_in_5;
        o_task.samples[6] = i_item.sample_in_6;
        o_task.samples[7] = i_item.sample_in_7;
        o_task.count      = count;
        o_task.offset     = s_wrap[mrp_pkg::FRAC_W +: mrp_pkg::LANE_W];
        o_task.frac       = s_wrap[mrp_pkg::FRAC_W-1:0];
    end

    assign busy   = i_queue_status.full;
    assign o_push = start && !busy;

`ifndef NO_ASSERTIONS
    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (mrp_pkg::CNT_W'(o_task.offset) < o_task.count))
        else $error("rotation offset not below the channel count");
    a_count_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_task.count >= mrp_pkg::CNT_W'(mrp_pkg::MIN_CHANNELS) &&
                    o_task.count <= mrp_pkg::CNT_W'(mrp_pkg::MAX_CHANNELS)))
        else $error("channel count outside the clamped range");
`endif

endmodule

// File: design/mrp_queue.sv
// Short queue of classified frames between the front end and the mixer.
// Depends on mrp_pkg.
module mrp_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  mrp_pkg::t_task          i_task,
    input  logic                    i_pop,
    output mrp_pkg::t_queue_status  o_status,
    output mrp_pkg::t_task          o_task
);

    mrp_pkg::t_task                r_entry [mrp_pkg::QUEUE_DEPTH];
    logic [mrp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mrp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mrp_pkg::QCNT_W-1:0]    r_count;
    logic [mrp_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [mrp_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic                          do_push;
    logic                          do_pop;

    assign o_status.full  = (r_count == mrp_pkg::QCNT_W'(mrp_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_task         = r_entry[r_rd_ptr];

    always_comb begin
        if (r_wr_ptr == mrp_pkg::QPTR_W'(mrp_pkg::QUEUE_DEPTH - 1)) begin
            n_wr_ptr = '0;
        end else begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (r_rd_ptr == mrp_pkg::QPTR_W'(mrp_pkg::QUEUE_DEPTH - 1)) begin
            n_rd_ptr = '0;
        end else begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_task;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("item pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("item popped from an empty queue");
`endif

endmodule

// File: design/mrp_back.sv
// Back end of the panner: gain interpolation from the quarter-sine table,
// lane rotation, two-tap mixing, rounding and saturation over five stages.
// Depends on mrp_pkg.
module mrp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mrp_pkg::t_task       i_task,
    output logic                 o_valid,
    output mrp_pkg::t_out_item   o_item
);

    localparam int MAXC = mrp_pkg::MAX_CHANNELS;
    localparam int P_W  = mrp_pkg::GAIN_W + mrp_pkg::IDX_W;
    localparam int D_W  = mrp_pkg::CNT_W + 1;
    localparam int ACC_W = 2 * mrp_pkg::SAMPLE_W + 1;

    // Stage 1 inputs: table lookups and lane selection.
    logic [mrp_pkg::GAIN_W-1:0]   q      [2];
    logic [P_W-1:0]               p      [2];
    logic [mrp_pkg::IDX_W-1:0]    idx    [2];
    logic [mrp_pkg::IDX_W-1:0]    idx_nx [2];
    logic [mrp_pkg::GAIN_W-1:0]   n_lo   [2];
    logic [mrp_pkg::GAIN_W-1:0]   n_hi   [2];
    logic [mrp_pkg::FRAC_W-1:0]   n_f    [2];
    logic signed [D_W-1:0]        diff   [MAXC];
    logic signed [D_W-1:0]        a_pos  [MAXC];
    logic [mrp_pkg::LANE_W-1:0]   a_idx  [MAXC];
    logic [mrp_pkg::LANE_W-1:0]   b_idx  [MAXC];
    mrp_pkg::t_lanes              n_a;
    mrp_pkg::t_lanes              n_b;

    logic                         r1_valid;
    logic [mrp_pkg::GAIN_W-1:0]   r1_lo  [2];
    logic [mrp_pkg::GAIN_W-1:0]   r1_hi  [2];
    logic [mrp_pkg::FRAC_W-1:0]   r1_f   [2];
    mrp_pkg::t_lanes              r1_a;
    mrp_pkg::t_lanes              r1_b;
    logic [mrp_pkg::CNT_W-1:0]    r1_count;

    logic                         r2_valid;
    logic [31:0]                  r2_plo [2];
    logic [31:0]                  r2_phi [2];
    mrp_pkg::t_lanes              r2_a;
    mrp_pkg::t_lanes              r2_b;
    logic [mrp_pkg::CNT_W-1:0]    r2_count;

    logic                         r3_valid;
    logic [mrp_pkg::GAIN_W-1:0]   r3_gain [2];
    mrp_pkg::t_lanes              r3_a;
    mrp_pkg::t_lanes              r3_b;
    logic [mrp_pkg::CNT_W-1:0]    r3_count;
    logic [31:0]                  n_gsum  [2];

    logic                         r4_valid;
    logic signed [31:0]           r4_pa  [MAXC];
    logic signed [31:0]           r4_pb  [MAXC];
    logic [mrp_pkg::CNT_W-1:0]    r4_count;

    logic signed [ACC_W-1:0]      acc    [MAXC];
    logic signed [ACC_W-16:0]     rnd    [MAXC];
    mrp_pkg::t_lanes              n_out;

    logic                         r_out_valid;
    mrp_pkg::t_lanes              r_out;

    // g1 uses the phase a quarter turn minus frac, g2 uses frac itself.
    always_comb begin
        q[0] = mrp_pkg::GAIN_W'(mrp_pkg::ONE_Q15) - {1'b0, i_task.frac};
        q[1] = {1'b0, i_task.frac};
        for (int g = 0; g < 2; g++) begin
            p[g]   = P_W'(q[g]) * P_W'(mrp_pkg::GAIN_TABLE_SIZE);
            idx[g] = p[g][mrp_pkg::FRAC_W +: mrp_pkg::IDX_W];
            n_f[g] = p[g][mrp_pkg::FRAC_W-1:0];
            // At full scale both interpolation points are the last entry.
            if (idx[g] >= mrp_pkg::IDX_W'(mrp_pkg::GAIN_TABLE_SIZE)) begin
                idx_nx[g] = idx[g];
            end else begin
                idx_nx[g] = idx[g] + 1'b1;
            end
            n_lo[g] = mrp_pkg::GAIN_ROM[idx[g]];
            n_hi[g] = mrp_pkg::GAIN_ROM[idx_nx[g]];
        end
    end

    always_comb begin
        for (int k = 0; k < MAXC; k++) begin
            diff[k] = D_W'(k) - D_W'(i_task.offset);
            if (diff[k][D_W-1]) begin
                a_pos[k] = diff[k] + D_W'(i_task.count);
            end else begin
                a_pos[k] = diff[k];
            end
            a_idx[k] = a_pos[k][mrp_pkg::LANE_W-1:0];
            if (a_idx[k] == '0) begin
                b_idx[k] = mrp_pkg::LANE_W'(i_task.count - 1'b1);
            end else begin
                b_idx[k] = a_idx[k] - 1'b1;
            end
            n_a[k] = i_task.samples[a_idx[k]];
            n_b[k] = i_task.samples[b_idx[k]];
        end
    end

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n_gsum[g] = r2_plo[g] + r2_phi[g] + 32'd16384;
        end
    end

    always_comb begin
        for (int k = 0; k < MAXC; k++) begin
            acc[k] = ACC_W'(r4_pa[k]) + ACC_W'(r4_pb[k]) + ACC_W'(16384);
            rnd[k] = acc[k][ACC_W-1:15];
            if (mrp_pkg::CNT_W'(k) >= r4_count) begin
                n_out[k] = '0;
            end else if (rnd[k] > (ACC_W-15)'(32767)) begin
                n_out[k] = 16'sh7FFF;
            end else if (rnd[k] < -(ACC_W-15)'(32768)) begin
                n_out[k] = 16'sh8000;
            end else begin
                n_out[k] = rnd[k][mrp_pkg::SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 2; g++) begin
            r1_lo[g]   <= n_lo[g];
            r1_hi[g]   <= n_hi[g];
            r1_f[g]    <= n_f[g];
            r2_plo[g]  <= 32'(r1_lo[g]) *
                          32'(mrp_pkg::GAIN_W'(mrp_pkg::ONE_Q15) - {1'b0, r1_f[g]});
            r2_phi[g]  <= 32'(r1_hi[g]) * 32'(r1_f[g]);
            r3_gain[g] <= n_gsum[g][mrp_pkg::FRAC_W +: mrp_pkg::GAIN_W];
        end
        r1_a     <= n_a;
        r1_b     <= n_b;
        r1_count <= i_task.count;
        r2_a     <= r1_a;
        r2_b     <= r1_b;
        r2_count <= r1_count;
        r3_a     <= r2_a;
        r3_b     <= r2_b;
        r3_count <= r2_count;
        for (int k = 0; k < MAXC; k++) begin
            r4_pa[k] <= $signed({1'b0, r3_gain[0]}) * $signed(r3_a[k]);
            r4_pb[k] <= $signed({1'b0, r3_gain[1]}) * $signed(r3_b[k]);
        end
        r4_count <= r3_count;
        r_out    <= n_out;
    end

    assign o_valid             = r_out_valid;
    assign o_item.sample_out_0 = r_out[0];
    assign o_item.sample_out_1 = r_out[1];
    assign o_item.sample_out_2 = r_out[2];
    assign o_item.sample_out_3 = r_out[3];
    assign o_item.sample_out_4 = r_out[4];
    assign o_item.sample_out_5 = r_out[5];
    assign o_item.sample_out_6 = r_out[6];
    assign o_item.sample_out_7 = r_out[7];

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##5 o_valid)
        else $error("item did not reach the output five cycles after entry");
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, 5))
        else $error("result strobe without a matching item");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the multichannel rotation panner.
// Drives random and directed frames, predicts each rotated frame from the gains, and compares.
// Depends on mrp_pkg and multichannel_rotation_panner from the design folder.
`timescale 1ns / 100ps

module tb;

    typedef longint unsigned u64;

    localparam int NCH = mrp_pkg::MAX_CHANNELS;
    localparam int GAIN_N = mrp_pkg::GAIN_TABLE_SIZE;
    localparam int SETTLE_CYCLES = 10;
    localparam int FRAMES_PER_SETTING = 138;
    localparam int REPORT_LIMIT = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mrp_pkg::CFG_W-1:0] i_cfg_data;
    logic start = 1'b0;
    mrp_pkg::t_in_item i_item = '0;
    logic busy;
    logic o_valid;
    mrp_pkg::t_out_item o_item;

    u64 sine_rom [0:mrp_pkg::GAIN_TABLE_SIZE];
    logic [mrp_pkg::CFG_W-1:0] cfg_count;
    mrp_pkg::t_in_item frames_pending[$];
    mrp_pkg::t_out_item expected_frames[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int phase_counts[12] = '{15, 3, 0, 4, 5, 1, 6, 7, 9, 8, 2, 10};
    mrp_pkg::t_out_item want_frame;

    multichannel_rotation_panner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Quarter-sine table: truncating Taylor series in Q2.30, rounded to Q1.15.
    function automatic void build_sine_rom();
        u64 x;
        u64 x2;
        u64 term;
        u64 g;
        longint acc;
        for (int k = 0; k <= GAIN_N; k++) begin
            x = (u64'(k) * u64'(mrp_pkg::HALF_PI_Q30)) / GAIN_N;
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (int n = 1; n <= 5; n++) begin
                term = ((term * x2) >> 30) / u64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            g = (u64'(acc) + 16384) >> 15;
            if (g > mrp_pkg::ONE_Q15) begin
                g = mrp_pkg::ONE_Q15;
            end
            sine_rom[k] = g;
        end
    endfunction

    function automatic u64 quarter_gain(int unsigned q);
        u64 p;
        u64 idx;
        u64 f;
        u64 v;
        p = u64'(q) * GAIN_N;
        idx = p >> 15;
        f = p & 64'h7FFF;
        if (idx >= GAIN_N) begin
            return sine_rom[GAIN_N];
        end
        v = sine_rom[idx] * (mrp_pkg::ONE_Q15 - f) + sine_rom[idx + 1] * f;
        return (v + 16384) >> 15;
    endfunction

    // Lanes are kept as t_lanes, where lane k sits at index NCH-1-k
    // so that the packed layout matches the item structs.
    function automatic mrp_pkg::t_out_item predict_rotation(mrp_pkg::t_in_item frame,
                                                            logic [mrp_pkg::CFG_W-1:0] count_reg);
        mrp_pkg::t_lanes src;
        mrp_pkg::t_lanes mixed;
        int c;
        int span;
        int s;
        int offset;
        int frac;
        int a;
        int b;
        longint g1;
        longint g2;
        longint acc;
        longint r;
        src = {frame.sample_in_0, frame.sample_in_1, frame.sample_in_2, frame.sample_in_3,
               frame.sample_in_4, frame.sample_in_5, frame.sample_in_6, frame.sample_in_7};
        c = int'(count_reg);
        if (c < mrp_pkg::MIN_CHANNELS) begin
            c = mrp_pkg::MIN_CHANNELS;
        end
        if (c > NCH) begin
            c = NCH;
        end
        span = c * mrp_pkg::ONE_Q15;
        s = int'(frame.rotation) * c;
        if (s <= -span || s >= span) begin
            s = 0;
        end
        if (s < 0) begin
            s = s + span;
        end
        offset = s >> mrp_pkg::FRAC_W;
        frac = s & 32'h7FFF;
        g1 = longint'(quarter_gain(mrp_pkg::ONE_Q15 - frac));
        g2 = longint'(quarter_gain(frac));
        mixed = '0;
        for (int k = 0; k < c; k++) begin
            a = (k + c - offset) % c;
            b = (k + 2 * c - offset - 1) % c;
            acc = g1 * longint'(src[NCH-1-a]) + g2 * longint'(src[NCH-1-b]);
            r = (acc + 16384) >>> 15;
            if (r > 32767) begin
                r = 32767;
            end
            if (r < -32768) begin
                r = -32768;
            end
            mixed[NCH-1-k] = mrp_pkg::t_sample'(r);
        end
        return mrp_pkg::t_out_item'(mixed);
    endfunction

    function automatic mrp_pkg::t_sample random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return mrp_pkg::t_sample'(int'($urandom_range(0, 64)) - 32);
            default: return mrp_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic mrp_pkg::t_in_item random_frame(int c);
        mrp_pkg::t_lanes lanes;
        mrp_pkg::t_sample rot;
        int turn;
        for (int k = 0; k < NCH; k++) begin
            lanes[k] = random_sample();
        end
        case ($urandom_range(0, 9))
            0: rot = 16'sh8000;
            1: rot = 16'sh7FFF;
            2: begin
                // Whole-channel steps, where the position falls on or just beside a channel boundary.
                turn = int'($urandom_range(0, 2 * c - 1)) - c;
                rot = mrp_pkg::t_sample'(turn * mrp_pkg::ONE_Q15 / c);
            end
            3: rot = mrp_pkg::t_sample'(int'($urandom_range(0, 512)) - 256);
            default: rot = mrp_pkg::t_sample'($urandom);
        endcase
        return mrp_pkg::t_in_item'({lanes, rot});
    endfunction

    function automatic mrp_pkg::t_in_item ramp_frame(mrp_pkg::t_sample rot);
        mrp_pkg::t_lanes lanes;
        for (int k = 0; k < NCH; k++) begin
            lanes[NCH-1-k] = mrp_pkg::t_sample'((k + 1) * 3000 - 12000);
        end
        return mrp_pkg::t_in_item'({lanes, rot});
    endfunction

    function automatic mrp_pkg::t_in_item flat_frame(mrp_pkg::t_sample even_val,
                                                     mrp_pkg::t_sample odd_val,
                                                     mrp_pkg::t_sample rot);
        mrp_pkg::t_lanes lanes;
        for (int k = 0; k < NCH; k++) begin
            lanes[NCH-1-k] = (k % 2 == 0) ? even_val : odd_val;
        end
        return mrp_pkg::t_in_item'({lanes, rot});
    endfunction

    task automatic compare_frame(mrp_pkg::t_out_item want, mrp_pkg::t_out_item got);
        mrp_pkg::t_lanes w;
        mrp_pkg::t_lanes g;
        w = want;
        g = got;
        for (int k = 0; k < NCH; k++) begin
            if (g[NCH-1-k] !== w[NCH-1-k]) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("%0t: sample_out_%0d expected %0d got %0d", $realtime, k,
                             w[NCH-1-k], g[NCH-1-k]);
                end
                mismatch_count++;
            end
        end
    endtask

    // Waits until every queued frame has been taken and every result has come back.
    task automatic settle();
        while (frames_pending.size() != 0 || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [mrp_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_count = value;
        @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps, some of them empty.
    always @(negedge i_clk) begin
        if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (frames_pending.size() > 0) begin
            start <= 1'b1;
            i_item <= frames_pending[0];
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_frames.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("%0t: result with no frame outstanding: %h", $realtime, o_item);
                end
                mismatch_count++;
            end else begin
                want_frame = expected_frames.pop_front();
                compare_frame(want_frame, o_item);
            end
        end
        if (i_rst_n && start === 1'b1 && busy === 1'b0) begin
            expected_frames.push_back(predict_rotation(i_item, cfg_count));
            void'(frames_pending.pop_front());
        end
    end

    initial begin
        build_sine_rom();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cfg_count = mrp_pkg::CFG_W'(mrp_pkg::CHANNEL_RESET);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset channel count: wrap of negative positions and the full-turn case.
        frames_pending.push_back(ramp_frame(16'sh0000));
        frames_pending.push_back(ramp_frame(16'sh8000));
        frames_pending.push_back(ramp_frame(16'sh4000));
        frames_pending.push_back(ramp_frame(16'shC000));
        frames_pending.push_back(ramp_frame(16'sh7FFF));
        frames_pending.push_back(ramp_frame(16'sh2000));
        settle();

        write_count(4'd8);
        frames_pending.push_back(ramp_frame(16'sh0000));
        frames_pending.push_back(ramp_frame(16'sh1000));
        frames_pending.push_back(ramp_frame(16'sh0800));
        frames_pending.push_back(ramp_frame(16'sh7FFF));
        frames_pending.push_back(ramp_frame(16'sh8000));
        frames_pending.push_back(ramp_frame(16'shFFFF));
        frames_pending.push_back(ramp_frame(16'sh0001));
        frames_pending.push_back(ramp_frame(16'shF000));
        frames_pending.push_back(ramp_frame(16'sh7000));
        frames_pending.push_back(ramp_frame(16'sh4000));
        // Full-scale inputs mixed at equal and at whole-step gains; like lanes at equal gains saturate.
        frames_pending.push_back(flat_frame(16'sh7FFF, 16'sh7FFF, 16'sh0800));
        frames_pending.push_back(flat_frame(16'sh8000, 16'sh8000, 16'sh0800));
        frames_pending.push_back(flat_frame(16'sh7FFF, 16'sh8000, 16'sh0800));
        frames_pending.push_back(flat_frame(16'sh8000, 16'sh7FFF, 16'sh0000));
        frames_pending.push_back(flat_frame(16'sh7FFF, 16'sh8000, 16'sh1000));
        settle();

        foreach (phase_counts[p]) begin
            write_count(mrp_pkg::CFG_W'(phase_counts[p]));
            for (int n = 0; n < FRAMES_PER_SETTING; n++) begin
                frames_pending.push_back(random_frame(
                    (phase_counts[p] < mrp_pkg::MIN_CHANNELS) ? mrp_pkg::MIN_CHANNELS :
                    (phase_counts[p] > NCH) ? NCH : phase_counts[p]));
            end
            settle();
        end

        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
